// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. All of them sample on clk and are
// held off while rst_n is low, so they are meant for modules with those ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever ante holds, cons holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lpr_pkg.sv =====
`default_nettype none

package lpr_pkg;

  // Widths fixed by the interface.
  localparam int PAGE_W    = 16;
  localparam int COUNT_W   = 32;
  localparam int CAP_W     = 5;
  localparam int USED_W    = 7;

  // Defaults for the top-level parameters.
  localparam int DEF_FRAMES    = 16;
  localparam int DEF_PAGE_BITS = 16;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Depth of the item queue and of the result queue.
  localparam int ITEM_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH  = 2;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } lpr_in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
    logic               sequence_end;
  } lpr_result_t;

  // Item handed from the front end to the back end; page already masked.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
  } lpr_item_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic [USED_W-1:0] used;
    logic              result_push;
    logic              result_hit;
    logic              result_evict;
    logic              result_last;
  } lpr_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_UPD
  } bk_state_t;

endpackage

`default_nettype wire

// ===== src/lpr_fifo.sv =====
`default_nettype none

module lpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/lpr_front.sv =====
`default_nettype none

module lpr_front
  import lpr_pkg::*;
#(
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lpr_in_t   in_data,
  output logic      full,
  input  logic      item_pop,
  output lpr_item_t item,
  output logic      item_empty
);

  // Only the low PAGE_BITS bits of a reference take part in matching.
  localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((17'd1 << TAG_W) - 17'd1);

  lpr_item_t item_in;

  always_comb begin
    item_in.page = in_data.page_number & PAGE_MASK;
    item_in.last = in_data.last_reference;
  end

  lpr_fifo #(
    .WIDTH ($bits(lpr_item_t)),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (item_empty)
  );

endmodule

`default_nettype wire

// ===== src/lpr_back.sv =====
`default_nettype none

module lpr_back
  import lpr_pkg::*;
#(
  parameter int FRAMES    = DEF_FRAMES,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] frames_in_use,
  input  lpr_item_t        item,
  input  logic             item_empty,
  output logic             item_pop,
  output lpr_result_t      result,
  output logic             result_push,
  input  logic             result_full,
  output lpr_status_t      status
);

  localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW    = $clog2(FRAMES + 1);
  localparam logic [USED_W-1:0] FRAMES_U = USED_W'(FRAMES);

  bk_state_t state_r, state_nxt;
  logic      look_en, upd_en;

  // Frame table.
  logic [TAG_W-1:0] page_r  [FRAMES];
  logic [RW-1:0]    rank_r  [FRAMES];
  logic [FRAMES-1:0] valid_r;
  logic [CW-1:0]    used_r;
  logic [COUNT_W-1:0] faults_r;

  // Item under work and the decision taken in the lookup cycle.
  lpr_item_t         item_r;
  logic [FRAMES-1:0] sel_r;
  logic [RW-1:0]     lim_r;
  logic              age_all_r, hit_r, fill_r, evict_r;
  logic [TAG_W-1:0]  evp_r;
  logic [COUNT_W-1:0] fc_r;

  // Lookup logic.
  logic [TAG_W-1:0]  tag;
  logic [FRAMES-1:0] match, victim, free_one;
  logic              hit, fill;
  logic [RW-1:0]     found_rank, oldest_rank;
  logic [TAG_W-1:0]  evp;
  logic [CW-1:0]     cap;
  logic [USED_W-1:0] cfg_ext;

  assign tag = item_r.page[TAG_W-1:0];

  always_comb begin
    cfg_ext = USED_W'(frames_in_use);
    if (cfg_ext == '0) begin
      cap = CW'(1);
    end else if (cfg_ext > FRAMES_U) begin
      cap = CW'(FRAMES);
    end else begin
      cap = CW'(cfg_ext);
    end
  end

  // Ranks of the valid frames always form 0 .. used-1, so the least
  // recently used frame is the one whose rank is used-1.
  assign oldest_rank = RW'(used_r - CW'(1));
  assign free_one    = ~valid_r & (valid_r + FRAMES'(1));

  always_comb begin
    found_rank = '0;
    evp        = '0;
    for (int f = 0; f < FRAMES; f++) begin
      match[f]  = valid_r[f] && (page_r[f] == tag);
      victim[f] = valid_r[f] && (rank_r[f] == oldest_rank);
      if (match[f]) begin
        found_rank = found_rank | rank_r[f];
      end
      if (victim[f]) begin
        evp = evp | page_r[f];
      end
    end
    hit  = |match;
    fill = !hit && (used_r < cap);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!item_empty) state_nxt = BK_LOOK;
      BK_LOOK: state_nxt = BK_UPD;
      BK_UPD: begin
        if (!result_full) begin
          state_nxt = item_empty ? BK_IDLE : BK_LOOK;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    item_pop    = 1'b0;
    look_en     = 1'b0;
    upd_en      = 1'b0;
    result_push = 1'b0;
    unique case (state_r)
      BK_IDLE: item_pop = !item_empty;
      BK_LOOK: look_en = 1'b1;
      BK_UPD: begin
        if (!result_full) begin
          upd_en      = 1'b1;
          result_push = 1'b1;
          item_pop    = !item_empty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      item_r <= item;
    end
    if (look_en) begin
      hit_r     <= hit;
      fill_r    <= fill;
      evict_r   <= !hit && !fill;
      age_all_r <= fill;
      if (hit) begin
        sel_r <= match;
        lim_r <= found_rank;
      end else if (fill) begin
        sel_r <= free_one;
        lim_r <= '0;
      end else begin
        sel_r <= victim;
        lim_r <= oldest_rank;
      end
      evp_r <= (!hit && !fill) ? evp : '0;
      if (hit || faults_r == '1) begin
        fc_r <= faults_r;
      end else begin
        fc_r <= faults_r + COUNT_W'(1);
      end
    end
  end

  // Table update; the last reference of a sequence clears everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      used_r   <= '0;
      faults_r <= '0;
      for (int f = 0; f < FRAMES; f++) begin
        rank_r[f] <= '0;
      end
    end else if (upd_en) begin
      if (item_r.last) begin
        valid_r  <= '0;
        used_r   <= '0;
        faults_r <= '0;
        for (int f = 0; f < FRAMES; f++) begin
          rank_r[f] <= '0;
        end
      end else begin
        faults_r <= fc_r;
        if (fill_r) begin
          used_r <= used_r + CW'(1);
        end
        for (int f = 0; f < FRAMES; f++) begin
          if (sel_r[f]) begin
            valid_r[f] <= 1'b1;
            rank_r[f]  <= '0;
          end else if (valid_r[f] && (age_all_r || rank_r[f] < lim_r)) begin
            rank_r[f] <= rank_r[f] + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && !item_r.last) begin
      for (int f = 0; f < FRAMES; f++) begin
        if (sel_r[f]) begin
          page_r[f] <= tag;
        end
      end
    end
  end

  always_comb begin
    result.hit           = hit_r;
    result.evicted_valid = evict_r;
    result.evicted_page  = PAGE_W'(evp_r);
    result.fault_count   = fc_r;
    result.sequence_end  = item_r.last;
  end

  always_comb begin
    status.used         = USED_W'(used_r);
    status.result_push  = result_push;
    status.result_hit   = hit_r;
    status.result_evict = evict_r;
    status.result_last  = item_r.last;
  end

endmodule

`default_nettype wire

// ===== src/lru_page_replacement_core.sv =====
`default_nettype none
// LRU page replacement core. Each transfer on the input queue carries one page
// reference; each transfer on the result queue reports whether that reference
// hit, which page (if any) was evicted, and the running fault count of the
// current sequence, which saturates at its maximum. Up to FRAMES pages are
// resident; cfg_wdata sets how many of them may be used (0 acts as 1, values
// above FRAMES act as FRAMES) and must only be written while the core is idle.
// A reference flagged as last ends a sequence: after its result the frame
// table and fault count are cleared. The back end handles one reference at a
// time, a lookup followed by an update over the frame table, and pulls the
// next reference from the input queue during the update. An idle core pulls
// a reference from the input queue, looks it up in the frame table, then
// updates the table and pushes the result onto the result queue. Two-entry
// queues on both sides let the producer and the consumer pause for a short
// while; once the result queue is full the back end waits in its update
// cycle until a result transfer frees an entry.

`include "assert_macros.svh"

module lru_page_replacement_core
  import lpr_pkg::*;
#(
  parameter int FRAMES    = DEF_FRAMES,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input queue side.
  input  logic             push,
  input  lpr_in_t          in_data,
  output logic             full,
  // Result queue side.
  output logic             empty,
  input  logic             pop,
  output lpr_result_t      out_data,
  // Capacity register.
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic [CAP_W-1:0] frames_in_use_r;
  lpr_item_t        item;
  logic             item_empty, item_pop;
  lpr_result_t      result;
  logic             result_push, result_full;
  lpr_status_t      status;

  // The capacity register is written whenever the enable is high. The back end
  // reads it live; the user keeps writes to idle, the core does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CAP_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  // Front end: accepts references, masks the page to PAGE_BITS, and queues
  // them for the back end.
  lpr_front #(
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .item_pop   (item_pop),
    .item       (item),
    .item_empty (item_empty)
  );

  // Back end: looks the page up in the frame table, then updates recency,
  // fills or evicts, and writes the result once the result queue has room.
  lpr_back #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .frames_in_use (frames_in_use_r),
    .item          (item),
    .item_empty    (item_empty),
    .item_pop      (item_pop),
    .result        (result),
    .result_push   (result_push),
    .result_full   (result_full),
    .status        (status)
  );

  // Result queue: the oldest waiting result sits on out_data while empty is
  // low, independent of what the back end is doing.
  lpr_fifo #(
    .WIDTH ($bits(lpr_result_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (result_push),
    .wdata (result),
    .full  (result_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  // A hit never evicts anything.
  `ASSERT_IMPLIES(a_hit_no_evict, status.result_push, !(status.result_hit && status.result_evict), "hit result reports an eviction")
  // Occupancy never exceeds the number of frames.
  `ASSERT_ALWAYS(a_used_bound, status.used <= USED_W'(FRAMES), "frame occupancy above FRAMES")
  // The table is empty right after the last result of a sequence.
  `ASSERT_NEXT(a_seq_clear, status.result_push && status.result_last, status.used == '0, "table not cleared after sequence end")

endmodule

`default_nettype wire

// ===== tb/sv/lru_page_replacement_checker.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_checker
  import lpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             full,
  input  lpr_in_t          in_data,
  input  logic             empty,
  input  logic             pop,
  input  lpr_result_t      out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               checked_count,
  output int               hit_count
);

  localparam int FRAMES    = DEF_FRAMES;
  localparam int PAGE_BITS = DEF_PAGE_BITS;
  localparam logic [PAGE_W-1:0] PAGE_MASK = {PAGE_W{1'b1}} >> (PAGE_W - PAGE_BITS);

  // Shadow of the frame table; age 0 is the most recently used frame.
  logic [PAGE_W-1:0]  frame_page  [FRAMES];
  logic               frame_valid [FRAMES];
  logic [3:0]         frame_age   [FRAMES];
  logic [COUNT_W-1:0] faults_in_seq;
  logic [CAP_W-1:0]   capacity;

  lpr_result_t predicted_outcomes [$];

  task automatic clear_frames();
    for (int f = 0; f < FRAMES; f++) begin
      frame_page[f]  = '0;
      frame_valid[f] = 1'b0;
      frame_age[f]   = '0;
    end
    faults_in_seq = '0;
  endtask

  task automatic age_younger(input int limit);
    for (int f = 0; f < FRAMES; f++) begin
      if (frame_valid[f] && int'(frame_age[f]) < limit) begin
        frame_age[f] = frame_age[f] + 1'b1;
      end
    end
  endtask

  // Applies one page reference to the shadow table and returns its outcome.
  task automatic resolve_reference(input lpr_in_t item, output lpr_result_t res);
    logic [PAGE_W-1:0] page;
    int cap;
    int used;
    int found;
    int slot;
    int oldest;
    page   = item.page_number & PAGE_MASK;
    cap    = int'(capacity);
    used   = 0;
    found  = -1;
    slot   = -1;
    oldest = 0;
    res    = '0;
    if (cap < 1) cap = 1;
    if (cap > FRAMES) cap = FRAMES;

    for (int f = 0; f < FRAMES; f++) begin
      if (frame_valid[f]) begin
        used++;
        if (found < 0 && frame_page[f] == page) found = f;
      end
    end

    if (found >= 0) begin
      res.hit = 1'b1;
      age_younger(int'(frame_age[found]));
      frame_age[found] = '0;
    end else begin
      if (faults_in_seq != '1) faults_in_seq = faults_in_seq + 1'b1;
      if (used < cap) begin
        for (int f = 0; f < FRAMES; f++) begin
          if (!frame_valid[f] && slot < 0) slot = f;
        end
      end
      if (slot >= 0) begin
        age_younger(FRAMES + 1);
      end else begin
        // Table is at (or above) capacity: the oldest resident page goes.
        for (int f = 0; f < FRAMES; f++) begin
          if (frame_valid[f] && (slot < 0 || int'(frame_age[f]) > oldest)) begin
            slot   = f;
            oldest = int'(frame_age[f]);
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[slot];
        age_younger(oldest);
      end
      frame_valid[slot] = 1'b1;
      frame_page[slot]  = page;
      frame_age[slot]   = '0;
    end

    res.fault_count  = faults_in_seq;
    res.sequence_end = item.last_reference;
    if (item.last_reference) clear_frames();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    lpr_result_t want;
    if (!rst_n) begin
      clear_frames();
      capacity = CAP_RESET;
      predicted_outcomes.delete();
      fail_count    = 0;
      checked_count = 0;
      hit_count     = 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (push && !full) begin
        resolve_reference(in_data, want);
        predicted_outcomes.push_back(want);
      end
      if (pop && !empty) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result transfer with no page reference outstanding");
          fail_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_data.hit));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(out_data.evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(out_data.evicted_page));
          check_field("fault_count", want.fault_count, out_data.fault_count);
          check_field("sequence_end", 32'(want.sequence_end), 32'(out_data.sequence_end));
          checked_count++;
          if (want.hit) hit_count++;
        end
      end
    end
    pending = predicted_outcomes.size();
  end

endmodule

// ===== tb/sv/lru_page_replacement_core_tb.sv =====
`timescale 1ns / 1ps

// Top of the LRU page replacement bench. This module only makes stimulus and
// gives the verdict; the checker beside the core watches every transfer,
// keeps its own copy of the frame table and compares each result.
module lru_page_replacement_core_tb;
  import lpr_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             push;
  lpr_in_t          in_data;
  logic             full;
  logic             empty;
  logic             pop;
  lpr_result_t      out_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked_count;
  int hit_count;

  // Bookkeeping for the stimulus side and for the closing summary.
  int               refs_sent;
  int               seq_count;
  int               cap_writes;
  bit               sender_quiet;
  logic [CAP_W-1:0] cur_cap;

  lru_page_replacement_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_page_replacement_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data       (in_data),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .hit_count     (hit_count)
  );

  // 12 ns clock, 6 ns high and 6 ns low.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("lru_page_replacement_core_tb: errors");
    $finish;
  end

  // Idle length used by both sides: mostly back to back, sometimes a short
  // pause, and now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Capacity as the core applies it: 0 behaves as 1, anything above the
  // frame count behaves as the full table.
  function automatic int usable_frames(input logic [CAP_W-1:0] value);
    if (value == 0) return 1;
    if (int'(value) > DEF_FRAMES) return DEF_FRAMES;
    return int'(value);
  endfunction

  // Offers one page reference. Called at a falling edge; it returns at a
  // falling edge with push still high unless an idle gap follows, so a
  // back-to-back transfer never lowers and raises push in the same step.
  task automatic offer(input logic [PAGE_W-1:0] page, input logic last);
    lpr_in_t item;
    int gap;
    item.page_number    = page;
    item.last_reference = last;
    push    <= 1'b1;
    in_data <= item;
    // The transfer happens at the first rising edge where full is low.
    do @(posedge clk); while (full);
    refs_sent++;
    if (last) seq_count++;
    @(negedge clk);
    gap = sender_quiet ? 0 : idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Writes the capacity register once the core has drained. Every reference
  // produces exactly one result, so an empty expectation queue means the
  // core holds no work in flight.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_cap = value;
    cap_writes++;
  endtask

  // Result side. Pop is raised and held until a transfer completes, then an
  // idle gap may follow. Twice in the run the consumer stops for a long
  // stretch while the producer keeps offering, so both queues fill and the
  // core has to push back with full.
  initial begin : drain_results
    int popped;
    int gap;
    bit quiet;
    pop    = 1'b0;
    popped = 0;
    quiet  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      popped++;
      @(negedge clk);
      // Switch between stretches with and without idling now and then.
      if (popped % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (popped == 100 || popped == 350) gap = 80;
      else gap = quiet ? 0 : idle_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int               seq_left;
    int               pool_size;
    int               phase_len;
    int               pick;
    int               waited;
    logic [PAGE_W-1:0] pool_base;
    logic [PAGE_W-1:0] page;
    logic             last;
    logic [CAP_W-1:0] new_cap;

    push         = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    refs_sent    = 0;
    seq_count    = 0;
    cap_writes   = 0;
    sender_quiet = 1'b0;
    cur_cap      = CAP_RESET;
    seq_left     = 0;
    pool_size    = 1;
    pool_base    = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A capacity of zero must act as a single frame: the
    // second page evicts the first, and a repeat of it is a hit.
    set_capacity(5'd0);
    offer(16'h0000, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h5555, 1'b1);

    // Three frames: fill them, refresh page 1 by a hit, then two faults
    // that replace the least recently used pages. The sequence stays open.
    set_capacity(5'd3);
    offer(16'h0001, 1'b0);
    offer(16'h0002, 1'b0);
    offer(16'h0003, 1'b0);
    offer(16'h0001, 1'b0);
    offer(16'h0004, 1'b0);
    offer(16'h0002, 1'b0);

    // Capacity lowered below the occupancy in the middle of that sequence:
    // faults still evict the oldest page, and resident pages still hit.
    set_capacity(5'd1);
    offer(16'h0007, 1'b0);
    offer(16'h0004, 1'b0);
    offer(16'h0009, 1'b1);

    // The largest register value is clamped to the full table.
    set_capacity(5'd31);
    offer(16'hAAAA, 1'b0);
    offer(16'h0000, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'hAAAA, 1'b0);
    offer(16'h8001, 1'b1);

    // Random part in phases, each under one capacity setting. Sequences
    // draw pages from a pool a little larger than the usable frames so that
    // hits, fills and evictions all show up; some pages are drawn from the
    // whole range and a few sequences end early. A sequence may run across
    // a phase boundary, which changes the capacity under a live table.
    while (refs_sent < 550) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: begin
          new_cap = 5'd0;
        end
        1: begin
          new_cap = 5'd1;
        end
        2: begin
          new_cap = 5'd16;
        end
        3: begin
          new_cap = 5'd17;
        end
        4: begin
          new_cap = 5'd31;
        end
        default: begin
          new_cap = CAP_W'($urandom_range(2, 15));
        end
      endcase
      set_capacity(new_cap);
      sender_quiet = ($urandom_range(0, 3) == 0);
      phase_len    = $urandom_range(30, 80);

      for (int i = 0; i < phase_len && refs_sent < 550; i++) begin
        if (seq_left == 0) begin
          seq_left  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 60);
          pool_size = usable_frames(cur_cap) + $urandom_range(0, 6);
          pool_base = PAGE_W'($urandom);
        end
        if ($urandom_range(0, 99) < 12) page = PAGE_W'($urandom);
        else page = pool_base + PAGE_W'($urandom_range(0, pool_size - 1));
        last     = (seq_left == 1) || ($urandom_range(0, 99) < 3);
        seq_left = last ? 0 : seq_left - 1;
        offer(page, last);
      end
    end

    // All references are in. Wait for the outstanding results, then keep
    // watching the core for any stray result transfer.
    push <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("Covered %0d page references in %0d closed sequences over %0d capacity writes.",
             refs_sent, seq_count, cap_writes);
    $display("Checked %0d results (%0d hits), with two long result-side holds.",
             checked_count, hit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("lru_page_replacement_core_tb: clean");
    end else begin
      $display("lru_page_replacement_core_tb: errors");
    end
    $finish;
  end

endmodule
